>>> rtl/core/v4nr_pkg.sv
package v4nr_pkg;

  typedef enum logic [1:0] {
    MODE_LEN_SQ  = 2'd0,
    MODE_LEN     = 2'd1,
    MODE_NORM    = 2'd2,
    MODE_REFLECT = 2'd3
  } mode_t;

  localparam int COMP_W = 32;
  localparam int SQ_W   = 66;   // sum of four 32x32 squares, unsigned
  localparam int ROOT_W = 64;   // Q32.32 root
  localparam int RAD_W  = 128;  // radicand width
  localparam int QUO_W  = 64;   // normalize quotient width
  localparam int NUM_W  = 64;   // normalize numerator width
  localparam int DOT_W  = 66;   // signed dot product
  localparam int RP_W   = 98;   // signed dot times normal

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] vx, vy, vz, vw;
    logic signed [31:0] nx, ny, nz, nw;
  } item_t;

  typedef struct packed {
    logic signed [31:0] rx, ry, rz, rw;
    logic [62:0]        scalar;
    logic               zero_length;
    logic               saturated;
  } result_t;

endpackage

>>> rtl/core/v4nr_sqrt_cell.sv
// One root bit per cell.
module v4nr_sqrt_cell import v4nr_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_in,
  input  logic [ROOT_W-1:0] root_in,
  input  logic [ROOT_W+1:0] rem_in,
  output logic [RAD_W-1:0]  rad_out,
  output logic [ROOT_W-1:0] root_out,
  output logic [ROOT_W+1:0] rem_out
);

  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] test;
  logic              take;

  always_comb begin
    rem_sh = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1 -: 2]};
    test   = {root_in, 2'b01};
    take   = rem_sh >= test;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[RAD_W-3:0], 2'b00};
      root_out <= {root_in[ROOT_W-2:0], take};
      rem_out  <= take ? rem_sh - test : rem_sh;
    end
  end

endmodule

>>> rtl/core/v4nr_div_cell.sv
// One quotient bit per cell, restoring division, four lanes sharing a divisor.
module v4nr_div_cell import v4nr_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ROOT_W-1:0]      den,
  input  logic [3:0][NUM_W-1:0]  num_in,
  input  logic [3:0][ROOT_W:0]   rem_in,
  input  logic [3:0][QUO_W-1:0]  quo_in,
  output logic [3:0][NUM_W-1:0]  num_out,
  output logic [3:0][ROOT_W:0]   rem_out,
  output logic [3:0][QUO_W-1:0]  quo_out
);

  logic [3:0][ROOT_W+1:0] rem_sh;
  logic [3:0]             take;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rem_sh[i] = {rem_in[i], num_in[i][NUM_W-1]};
      take[i]   = rem_sh[i] >= {2'b00, den};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        num_out[i] <= {num_in[i][NUM_W-2:0], 1'b0};
        quo_out[i] <= {quo_in[i][QUO_W-2:0], take[i]};
        rem_out[i] <= take[i] ? (ROOT_W+1)'(rem_sh[i] - {2'b00, den})
                              : rem_sh[i][ROOT_W:0];
      end
    end
  end

endmodule

>>> rtl/core/vector4_length_normalize_reflect.sv
// Fully pipelined four-component vector unit: one word accepted per clock
// while the output register is empty or out_tready is high. The pipeline is 4
// front stages (products, sums, dot times normal, reflect and radicand), 64
// square-root cells (one root bit per stage), 1 rounding stage, 64 divider
// cells for normalize (one quotient bit per stage) and 1 output stage. Stages
// stall together with the output register, so nothing is lost while out_tready
// is low; in_tready is high in the same cycle whenever they do not stall, and is low in reset.
module vector4_length_normalize_reflect import v4nr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode[1:0], vec_x, vec_y, vec_z, vec_w, normal_x, normal_y, normal_z, normal_w
  input  logic [263:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // res_x, res_y, res_z, res_w, scalar[62:0], zero_length, saturated
  output logic [199:0] out_tdata
);

  localparam int NSQ  = ROOT_W;
  localparam int NDIV = QUO_W;
  localparam int LAT  = 4 + NSQ + 1 + NDIV;
  localparam int F2   = 2 * FRAC_BITS;

  // whole pipeline advances only when output side can take data
  logic en;
  logic [LAT-1:0] vld_r;
  logic out_vld_r;
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en && rst_n;
  assign out_tvalid = out_vld_r;

  item_t it;
  assign it.mode = mode_t'(in_tdata[1:0]);
  assign it.vx = in_tdata[33:2];
  assign it.vy = in_tdata[65:34];
  assign it.vz = in_tdata[97:66];
  assign it.vw = in_tdata[129:98];
  assign it.nx = in_tdata[161:130];
  assign it.ny = in_tdata[193:162];
  assign it.nz = in_tdata[225:194];
  assign it.nw = in_tdata[257:226];

  // stage 1: products
  item_t s1_it_r;
  logic [3:0][63:0]        s1_sq_r;
  logic signed [3:0][63:0] s1_dp_r;
  // stage 2: sums
  item_t s2_it_r;
  logic [SQ_W-1:0]         s2_sum_r;
  logic signed [DOT_W-1:0] s2_dot_r;
  // stage 3: dot*n as high and low partial products
  item_t s3_it_r;
  logic [SQ_W-1:0]         s3_sum_r;
  logic signed [65:0]      s3_ph_r [4];
  logic signed [64:0]      s3_pl_r [4];
  // stage 4: reflect result, scalar square, radicand
  mode_t            s4_mode_r;
  logic signed [3:0][31:0] s4_v_r;
  logic [3:0][31:0] s4_refl_r;
  logic             s4_rsat_r;
  logic [62:0]      s4_sq_r;
  logic             s4_ssat_r;
  logic             s4_zero_r;
  logic [RAD_W-1:0] s4_rad_r;

  logic signed [RP_W+F2:0] rr [4];
  logic [3:0][31:0] refl;
  logic [3:0]       rsat;
  logic [SQ_W+32:0] sq_sh;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (i)
        0: rr[i] = (RP_W+F2+1)'($signed(s3_it_r.vx));
        1: rr[i] = (RP_W+F2+1)'($signed(s3_it_r.vy));
        2: rr[i] = (RP_W+F2+1)'($signed(s3_it_r.vz));
        default: rr[i] = (RP_W+F2+1)'($signed(s3_it_r.vw));
      endcase
      rr[i] = (rr[i] <<< F2) + ((RP_W+F2+1)'(1) <<< (F2 - 1))
              - ((RP_W+F2+1)'(s3_ph_r[i]) <<< 33)
              - ((RP_W+F2+1)'(s3_pl_r[i]) <<< 1);
      rr[i] = rr[i] >>> F2;
      if (rr[i] > (RP_W+F2+1)'(32'sh7fffffff)) begin
        refl[i] = 32'h7fffffff; rsat[i] = 1'b1;
      end else if (rr[i] < -(RP_W+F2+1)'(33'sh80000000)) begin
        refl[i] = 32'h80000000; rsat[i] = 1'b1;
      end else begin
        refl[i] = rr[i][31:0]; rsat[i] = 1'b0;
      end
    end
    if (F2 > 32)
      sq_sh = ((SQ_W+33)'(s3_sum_r) + ((SQ_W+33)'(1) << (F2 - 33))) >> (F2 - 32);
    else
      sq_sh = (SQ_W+33)'(s3_sum_r) << (32 - F2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_it_r <= it;
      s1_sq_r[0] <= 64'($signed(it.vx) * $signed(it.vx));
      s1_sq_r[1] <= 64'($signed(it.vy) * $signed(it.vy));
      s1_sq_r[2] <= 64'($signed(it.vz) * $signed(it.vz));
      s1_sq_r[3] <= 64'($signed(it.vw) * $signed(it.vw));
      s1_dp_r[0] <= 64'($signed(it.vx) * $signed(it.nx));
      s1_dp_r[1] <= 64'($signed(it.vy) * $signed(it.ny));
      s1_dp_r[2] <= 64'($signed(it.vz) * $signed(it.nz));
      s1_dp_r[3] <= 64'($signed(it.vw) * $signed(it.nw));

      s2_it_r  <= s1_it_r;
      s2_sum_r <= SQ_W'(s1_sq_r[0]) + SQ_W'(s1_sq_r[1])
                + SQ_W'(s1_sq_r[2]) + SQ_W'(s1_sq_r[3]);
      s2_dot_r <= DOT_W'($signed(s1_dp_r[0])) + DOT_W'($signed(s1_dp_r[1]))
                + DOT_W'($signed(s1_dp_r[2])) + DOT_W'($signed(s1_dp_r[3]));

      s3_it_r  <= s2_it_r;
      s3_sum_r <= s2_sum_r;
      s3_ph_r[0] <= $signed(s2_dot_r[65:32]) * $signed(s2_it_r.nx);
      s3_ph_r[1] <= $signed(s2_dot_r[65:32]) * $signed(s2_it_r.ny);
      s3_ph_r[2] <= $signed(s2_dot_r[65:32]) * $signed(s2_it_r.nz);
      s3_ph_r[3] <= $signed(s2_dot_r[65:32]) * $signed(s2_it_r.nw);
      s3_pl_r[0] <= $signed({1'b0, s2_dot_r[31:0]}) * $signed(s2_it_r.nx);
      s3_pl_r[1] <= $signed({1'b0, s2_dot_r[31:0]}) * $signed(s2_it_r.ny);
      s3_pl_r[2] <= $signed({1'b0, s2_dot_r[31:0]}) * $signed(s2_it_r.nz);
      s3_pl_r[3] <= $signed({1'b0, s2_dot_r[31:0]}) * $signed(s2_it_r.nw);

      s4_mode_r <= s3_it_r.mode;
      s4_v_r    <= {s3_it_r.vw, s3_it_r.vz, s3_it_r.vy, s3_it_r.vx};
      s4_refl_r <= refl;
      s4_rsat_r <= |rsat;
      s4_zero_r <= s3_sum_r == '0;
      s4_rad_r  <= RAD_W'(s3_sum_r) << (64 - F2);
      if (sq_sh[SQ_W+32:63] != '0) begin
        s4_sq_r <= '1; s4_ssat_r <= 1'b1;
      end else begin
        s4_sq_r <= sq_sh[62:0]; s4_ssat_r <= 1'b0;
      end
    end
  end

  // square-root chain, side data carried alongside
  typedef struct packed {
    mode_t            mode;
    logic [3:0][31:0] v;
    logic [3:0][31:0] refl;
    logic             rsat;
    logic [62:0]      sq;
    logic             ssat;
    logic             zero;
  } side_t;

  side_t s4_side;
  assign s4_side = '{s4_mode_r, s4_v_r, s4_refl_r, s4_rsat_r, s4_sq_r, s4_ssat_r, s4_zero_r};

  logic [RAD_W-1:0]  sq_rad  [NSQ+1];
  logic [ROOT_W-1:0] sq_root [NSQ+1];
  logic [ROOT_W+1:0] sq_rem  [NSQ+1];
  side_t             sq_side [NSQ+1];

  assign sq_rad[0]  = s4_rad_r;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = s4_side;

  for (genvar g = 0; g < NSQ; g++) begin : g_sq
    side_t side_r;
    v4nr_sqrt_cell u_cell (
      .clk(clk), .en(en),
      .rad_in(sq_rad[g]), .root_in(sq_root[g]), .rem_in(sq_rem[g]),
      .rad_out(sq_rad[g+1]), .root_out(sq_root[g+1]), .rem_out(sq_rem[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) side_r <= sq_side[g];
    end
    assign sq_side[g+1] = side_r;
  end

  // rounding stage
  side_t             r_side_r;
  logic [ROOT_W-1:0] len_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r_side_r <= sq_side[NSQ];
      len_r    <= (ROOT_W+2)'(sq_rem[NSQ]) > (ROOT_W+2)'(sq_root[NSQ])
                  ? sq_root[NSQ] + 1'b1 : sq_root[NSQ];
    end
  end

  // divider chain
  logic [3:0][NUM_W-1:0] dv_num [NDIV+1];
  logic [3:0][ROOT_W:0]  dv_rem [NDIV+1];
  logic [3:0][QUO_W-1:0] dv_quo [NDIV+1];
  logic [ROOT_W-1:0]     dv_den [NDIV+1];
  side_t                 dv_side [NDIV+1];
  logic [3:0][NUM_W-1:0] num0;

  always_comb begin
    for (int i = 0; i < 4; i++)
      num0[i] = {(r_side_r.v[i][31] ? 32'(-r_side_r.v[i]) : r_side_r.v[i]), 32'b0}
                + NUM_W'(len_r >> 1);
  end

  assign dv_num[0]  = num0;
  assign dv_rem[0]  = '0;
  assign dv_quo[0]  = '0;
  assign dv_den[0]  = len_r;
  assign dv_side[0] = r_side_r;

  for (genvar g = 0; g < NDIV; g++) begin : g_dv
    logic [ROOT_W-1:0] den_r;
    side_t             side_r;
    v4nr_div_cell u_cell (
      .clk(clk), .en(en), .den(dv_den[g]),
      .num_in(dv_num[g]), .rem_in(dv_rem[g]), .quo_in(dv_quo[g]),
      .num_out(dv_num[g+1]), .rem_out(dv_rem[g+1]), .quo_out(dv_quo[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        den_r  <= dv_den[g];
        side_r <= dv_side[g];
      end
    end
    assign dv_den[g+1]  = den_r;
    assign dv_side[g+1] = side_r;
  end

  // output stage
  result_t res_r;
  result_t res_nxt;
  side_t   so;
  logic [3:0][31:0] nrm;
  logic [3:0]       nsat;

  always_comb begin
    so = dv_side[NDIV];
    for (int i = 0; i < 4; i++) begin
      if (so.v[i][31]) begin
        if (dv_quo[NDIV][i] > 64'h80000000) begin
          nrm[i] = 32'h80000000; nsat[i] = 1'b1;
        end else begin
          nrm[i] = 32'(-dv_quo[NDIV][i]); nsat[i] = 1'b0;
        end
      end else if (dv_quo[NDIV][i] > 64'h7fffffff) begin
        nrm[i] = 32'h7fffffff; nsat[i] = 1'b1;
      end else begin
        nrm[i] = dv_quo[NDIV][i][31:0]; nsat[i] = 1'b0;
      end
    end
    res_nxt = '0;
    res_nxt.zero_length = so.zero;
    case (so.mode)
      MODE_LEN_SQ: begin
        res_nxt.scalar    = so.sq;
        res_nxt.saturated = so.ssat;
      end
      MODE_LEN: res_nxt.scalar = dv_den[NDIV][62:0];
      MODE_NORM: begin
        if (!so.zero) begin
          {res_nxt.rw, res_nxt.rz, res_nxt.ry, res_nxt.rx} = nrm;
          res_nxt.saturated = |nsat;
        end
      end
      default: begin
        {res_nxt.rw, res_nxt.rz, res_nxt.ry, res_nxt.rx} = so.refl;
        res_nxt.saturated = so.rsat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[LAT-2:0], in_tvalid};
      out_vld_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign out_tdata = {7'b0, res_r.saturated, res_r.zero_length, res_r.scalar,
                      res_r.rw, res_r.rz, res_r.ry, res_r.rx};

endmodule

>>> sim/v4nr_checker.sv
`timescale 1ns / 1ps
module v4nr_checker import v4nr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [263:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [199:0] out_tdata,
  output int           errors,
  output int           pending,
  output int           results_seen,
  output int           zero_seen
);

  typedef struct {
    logic [31:0] comp [4];
    logic [62:0] scalar;
    logic        zero_length;
    logic        saturated;
  } vec_result_t;

  vec_result_t expected_q [$];

  function automatic logic [31:0] clip32(logic signed [127:0] val, inout logic sat);
    logic signed [127:0] hi_lim, lo_lim;
    hi_lim = 128'sh7FFF_FFFF;
    lo_lim = -128'sh8000_0000;
    if (val > hi_lim) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (val < lo_lim) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return val[31:0];
  endfunction

  function automatic vec_result_t vec_unit(logic [263:0] d);
    mode_t               m;
    logic signed [127:0] v [4];
    logic signed [127:0] n [4];
    logic signed [127:0] dot, r, t, mag, qs;
    logic [127:0]        sum, rad, rem, tst, num, q;
    logic [63:0]         root;
    vec_result_t         e;
    logic                sat;
    m = mode_t'(d[1:0]);
    sum = '0;
    dot = '0;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      v[i] = $signed(d[2 + 32*i +: 32]);
      n[i] = $signed(d[130 + 32*i +: 32]);
      sum = sum + 128'(v[i] * v[i]);
      dot = dot + v[i] * n[i];
      e.comp[i] = '0;
    end
    e.scalar = '0;
    e.zero_length = (sum == 0);
    rad = sum << 32;
    rem = '0;
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      root = root << 1;
      rem = (rem << 2) | ((rad >> (2*k)) & 128'd3);
      tst = (128'(root) << 1) | 128'd1;
      if (rem >= tst) begin
        rem = rem - tst;
        root = root | 64'd1;
      end
    end
    if (rem > 128'(root)) root = root + 64'd1;
    case (m)
      MODE_LEN_SQ: begin
        if (sum > 128'h7FFF_FFFF_FFFF_FFFF) begin
          sat = 1'b1;
          e.scalar = '1;
        end else begin
          e.scalar = sum[62:0];
        end
      end
      MODE_LEN: e.scalar = root[62:0];
      MODE_NORM: begin
        if (sum != 0 && root != 0) begin
          for (int i = 0; i < 4; i++) begin
            mag = (v[i] < 0) ? -v[i] : v[i];
            num = (128'(mag) << 32) + 128'(root >> 1);
            q = num / 128'(root);
            qs = (v[i] < 0) ? -$signed(q) : $signed(q);
            e.comp[i] = clip32(qs, sat);
          end
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          t = dot * n[i];
          r = (v[i] <<< 32) - (t + t);
          r = (r + 128'sh8000_0000) >>> 32;
          e.comp[i] = clip32(r, sat);
        end
      end
    endcase
    e.saturated = sat;
    return e;
  endfunction

  always @(posedge clk) begin
    vec_result_t e;
    logic        bad;
    if (!rst_n) begin
      errors <= 0;
      pending <= 0;
      results_seen <= 0;
      zero_seen <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_q.push_back(vec_unit(in_tdata));
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result word %h", out_tdata);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.zero_length) zero_seen <= zero_seen + 1;
          bad = (out_tdata[190:128] !== e.scalar) || (out_tdata[191] !== e.zero_length)
                || (out_tdata[192] !== e.saturated);
          for (int i = 0; i < 4; i++)
            if (out_tdata[32*i +: 32] !== e.comp[i]) bad = 1'b1;
          if (bad) begin
            if (errors < 10)
              $display("mismatch: exp %h %h %h %h s=%h z=%b sat=%b got %h %h %h %h s=%h z=%b sat=%b",
                       e.comp[0], e.comp[1], e.comp[2], e.comp[3], e.scalar,
                       e.zero_length, e.saturated, out_tdata[31:0], out_tdata[63:32],
                       out_tdata[95:64], out_tdata[127:96], out_tdata[190:128],
                       out_tdata[191], out_tdata[192]);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench import v4nr_pkg::*; ();

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [263:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [199:0] out_tdata;
  int           errors, pending, results_seen, zero_seen;
  int           mode_count [4];
  int           sent;
  int           idle_cycles;
  logic         hold_req;

  localparam int WATCHDOG = 20000;
  localparam int N_ITEMS  = 1550;

  vector4_length_normalize_reflect uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  v4nr_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending), .results_seen(results_seen),
    .zero_seen(zero_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(0, 2 << 16)) - (1 << 16));
      3: return 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
      4: return 32'($urandom_range(0, 3)) - 32'd1;
      default: return 32'(signed'($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  task automatic send_word(mode_t m, logic [31:0] c [8]);
    logic [263:0] d;
    d = '0;
    d[1:0] = m;
    for (int i = 0; i < 8; i++) d[2 + 32*i +: 32] = c[i];
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mode_count[m]++;
    sent++;
  endtask

  task automatic send_fill(mode_t m, logic [31:0] vval, logic [31:0] nval);
    logic [31:0] c [8];
    for (int i = 0; i < 8; i++) c[i] = (i < 4) ? vval : nval;
    send_word(m, c);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_req) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 9) < 7) || ((sent / 200) % 2 == 1);
  end

  // long receiver hold-off while input keeps coming
  initial begin
    hold_req = 1'b0;
    wait (sent == 400);
    hold_req = 1'b1;
    repeat (600) @(posedge clk);
    hold_req = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [31:0] c [8];
    int          burst;
    sent = 0;
    foreach (mode_count[i]) mode_count[i] = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int m = 0; m < 4; m++) begin
      send_fill(mode_t'(m), 32'h0, 32'h0001_0000);
      send_fill(mode_t'(m), 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_fill(mode_t'(m), 32'h8000_0000, 32'h8000_0000);
      send_fill(mode_t'(m), 32'h0001_0000, 32'hFFFF_8000);
      send_fill(mode_t'(m), 32'h0000_0001, 32'h1234_5678);
    end
    c = '{32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0,
          32'h0001_0000, 32'h0, 32'h0, 32'h0};
    send_word(MODE_REFLECT, c);
    send_word(MODE_NORM, c);
    c = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000};
    send_word(MODE_NORM, c);
    send_word(MODE_REFLECT, c);
    in_tvalid <= 1'b0;

    while (sent < N_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < N_ITEMS; b++) begin
        for (int i = 0; i < 8; i++) c[i] = rand_comp();
        if ($urandom_range(0, 15) == 0) for (int i = 0; i < 4; i++) c[i] = '0;
        send_word(mode_t'($urandom_range(0, 3)), c);
      end
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d words in (len_sq %0d, len %0d, norm %0d, reflect %0d), %0d results",
             sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3], results_seen);
    $display("%0d zero-length vectors, one long output stall, %0d errors", zero_seen, errors);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
